### hw/rtl/address_resolution_cache_core_defines.svh
// Assertion macros shared by the address resolution cache RTL.
`ifndef ADDRESS_RESOLUTION_CACHE_CORE_DEFINES_SVH
`define ADDRESS_RESOLUTION_CACHE_CORE_DEFINES_SVH

`ifndef SYNTH
`define ARC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
	else $error("assertion failed");
`define ARC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define ARC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ARC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/arc_pkg.sv
// Shared types and constants of the address resolution cache.
`timescale 1ns / 1ps
package arc_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int IP_W        = 32;
	localparam int MAC_W       = 48;

	localparam logic MODE_UPDATE = 1'b0;
	localparam logic MODE_LOOKUP = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} arc_state_t;

endpackage

### hw/rtl/arc_table.sv
// Address and MAC storage with one write port, one registered read port and valid bits.
`timescale 1ns / 1ps
module arc_table #(
	parameter int ENTRIES = arc_pkg::ENTRIES_DEF,
	localparam int IW = $clog2(ENTRIES)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [IW-1:0]            rd_addr,
	output logic [arc_pkg::IP_W-1:0]  rd_ip,
	output logic [arc_pkg::MAC_W-1:0] rd_mac,
	input  logic                     wr_en,
	input  logic [IW-1:0]            wr_addr,
	input  logic [arc_pkg::IP_W-1:0]  wr_ip,
	input  logic [arc_pkg::MAC_W-1:0] wr_mac
);

	logic [arc_pkg::IP_W-1:0]  ip_mem [ENTRIES];
	logic [arc_pkg::MAC_W-1:0] mac_mem [ENTRIES];
	logic [ENTRIES-1:0]        valid_q;
	logic [arc_pkg::IP_W-1:0]  rd_ip_q;
	logic [arc_pkg::MAC_W-1:0] rd_mac_q;
	logic                      rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ip_mem[wr_addr]  <= wr_ip;
			mac_mem[wr_addr] <= wr_mac;
		end
		if (rd_en) begin
			rd_ip_q  <= ip_mem[rd_addr];
			rd_mac_q <= mac_mem[rd_addr];
		end
	end

	// An entry never written since reset reads as all zeros.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_ip  = rd_vld_q ? rd_ip_q  : '0;
	assign rd_mac = rd_vld_q ? rd_mac_q : '0;

endmodule

### hw/rtl/arc_seq.sv
// Sequencer that walks the table with one address comparator and applies the update.
`timescale 1ns / 1ps
module arc_seq #(
	parameter int ENTRIES = arc_pkg::ENTRIES_DEF,
	localparam int IW = $clog2(ENTRIES)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      mode,
	input  logic [arc_pkg::IP_W-1:0]  lookup_ip,
	input  logic [arc_pkg::MAC_W-1:0] new_mac,
	output logic                      busy,
	output logic                      done,
	output logic                      hit,
	output logic [arc_pkg::MAC_W-1:0] found_mac,
	output logic                      rd_en,
	output logic [IW-1:0]             rd_addr,
	input  logic [arc_pkg::IP_W-1:0]  rd_ip,
	input  logic [arc_pkg::MAC_W-1:0] rd_mac,
	output logic                      wr_en,
	output logic [IW-1:0]             wr_addr,
	output logic [arc_pkg::IP_W-1:0]  wr_ip,
	output logic [arc_pkg::MAC_W-1:0] wr_mac
);

	arc_pkg::arc_state_t state_q, state_d;

	logic [IW:0]               cnt_q;
	logic                      cmp_vld_s1;
	logic [IW-1:0]             cmp_idx_s1;
	logic                      mode_q;
	logic [arc_pkg::IP_W-1:0]  ip_q;
	logic [arc_pkg::MAC_W-1:0] mac_q;
	logic                      hit_q;
	logic [IW-1:0]             slot_q;
	logic [arc_pkg::MAC_W-1:0] found_mac_q;
	logic [IW-1:0]             victim_q;
	logic                      issue;
	logic                      match;
	logic                      last;

	assign issue = (state_q == arc_pkg::ST_SCAN) && (cnt_q != (IW+1)'(ENTRIES));
	assign match = cmp_vld_s1 && (rd_ip == ip_q);
	assign last  = cmp_vld_s1 && (cmp_idx_s1 == IW'(ENTRIES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= arc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		done    = 1'b0;
		wr_en   = 1'b0;
		case (state_q)
			arc_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = arc_pkg::ST_SCAN;
				end
			end
			arc_pkg::ST_SCAN: begin
				if (match || last) begin
					state_d = arc_pkg::ST_FINISH;
				end
			end
			arc_pkg::ST_FINISH: begin
				done    = 1'b1;
				wr_en   = (mode_q == arc_pkg::MODE_UPDATE);
				state_d = arc_pkg::ST_IDLE;
			end
			default: begin
				state_d = arc_pkg::ST_IDLE;
			end
		endcase
	end

	// Reads are issued one entry per cycle; each entry is compared in the cycle after its read is issued.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			victim_q   <= '0;
		end else begin
			cmp_vld_s1 <= issue;
			if (state_q == arc_pkg::ST_IDLE) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + (IW+1)'(1);
			end
			if (wr_en && !hit_q) begin
				victim_q <= (victim_q == IW'(ENTRIES - 1)) ? '0 : victim_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= cnt_q[IW-1:0];
		if (start && (state_q == arc_pkg::ST_IDLE)) begin
			mode_q <= mode;
			ip_q   <= lookup_ip;
			mac_q  <= new_mac;
		end
		if (state_q == arc_pkg::ST_SCAN) begin
			if (match) begin
				hit_q       <= 1'b1;
				slot_q      <= cmp_idx_s1;
				found_mac_q <= (mode_q == arc_pkg::MODE_LOOKUP) ? rd_mac : '0;
			end else if (last) begin
				hit_q       <= 1'b0;
				found_mac_q <= '0;
			end
		end
	end

	assign rd_en     = issue;
	assign rd_addr   = cnt_q[IW-1:0];
	assign wr_addr   = hit_q ? slot_q : victim_q;
	assign wr_ip     = ip_q;
	assign wr_mac    = mac_q;
	assign hit       = hit_q;
	assign found_mac = found_mac_q;

endmodule

### hw/rtl/address_resolution_cache_core.sv
// Top level of the address resolution cache: IPv4 to MAC table with round-robin insertion.
//
//   channel   | handshake          | payload
//   ----------+--------------------+-----------------------------
//   request   | start, busy        | mode, lookup_ip, new_mac
//   result    | done (one cycle)   | hit, found_mac
//
// A request is a transfer at an edge with start high and busy low.
// The table is scanned one entry per cycle through a single comparator on a
// registered memory read; a hit ends the scan at the lowest-indexed matching
// entry and a miss after the last entry, ending with the one-cycle done strobe.
// Reset clears the valid bits at once, so no clearing pass is needed.
// The result cannot be held off; the next request is taken the cycle after done.
`timescale 1ns / 1ps
`include "address_resolution_cache_core_defines.svh"
module address_resolution_cache_core #(
	parameter int ENTRIES = arc_pkg::ENTRIES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      mode,
	input  logic [arc_pkg::IP_W-1:0]  lookup_ip,
	input  logic [arc_pkg::MAC_W-1:0] new_mac,
	output logic                      done,
	output logic                      hit,
	output logic [arc_pkg::MAC_W-1:0] found_mac
);

	localparam int IW = $clog2(ENTRIES);

	logic                      rd_en;
	logic [IW-1:0]             rd_addr;
	logic [arc_pkg::IP_W-1:0]  rd_ip;
	logic [arc_pkg::MAC_W-1:0] rd_mac;
	logic                      wr_en;
	logic [IW-1:0]             wr_addr;
	logic [arc_pkg::IP_W-1:0]  wr_ip;
	logic [arc_pkg::MAC_W-1:0] wr_mac;

	arc_seq #(
		.ENTRIES (ENTRIES)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.mode      (mode),
		.lookup_ip (lookup_ip),
		.new_mac   (new_mac),
		.busy      (busy),
		.done      (done),
		.hit       (hit),
		.found_mac (found_mac),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_ip     (rd_ip),
		.rd_mac    (rd_mac),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_ip     (wr_ip),
		.wr_mac    (wr_mac)
	);

	arc_table #(
		.ENTRIES (ENTRIES)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_ip   (rd_ip),
		.rd_mac  (rd_mac),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_ip   (wr_ip),
		.wr_mac  (wr_mac)
	);

	`ARC_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`ARC_ASSERT_IMP(a_done_busy, clk, arst_n, done, busy)
	`ARC_ASSERT_NXT(a_done_idle, clk, arst_n, done, !busy && !done)
	`ARC_ASSERT_IMP(a_miss_zero, clk, arst_n, done && !hit, found_mac == '0)
	`ARC_ASSERT_IMP(a_no_rw, clk, arst_n, wr_en, !rd_en && done)

endmodule

### dv/testbench.sv
// Self-checking testbench for the address resolution cache core.
`timescale 1ns / 1ps
module testbench;
	import arc_pkg::*;

	localparam int DEPTH       = ENTRIES_DEF;
	localparam int RANDOM_REQS = 450;
	localparam int POOL_SIZE   = 24;
	localparam int MAX_GAP     = 25;
	localparam int TIMEOUT_NS  = 400000;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic             mode;
	logic [IP_W-1:0]  lookup_ip;
	logic [MAC_W-1:0] new_mac;
	logic             done;
	logic             hit;
	logic [MAC_W-1:0] found_mac;

	logic [IP_W-1:0]  addr_pool [POOL_SIZE];

	// Tracks the address table and the replies that are still owed by the block.
	class mac_table_tracker;
		typedef struct {
			logic             hit;
			logic [MAC_W-1:0] mac;
		} reply_t;

		logic [IP_W-1:0]  slot_ip [DEPTH];
		logic [MAC_W-1:0] slot_mac [DEPTH];
		int unsigned      next_victim;
		reply_t           pending_replies [$];
		int               mismatches;

		function new();
			int k;
			for (k = 0; k < DEPTH; k++) begin
				slot_ip[k]  = '0;
				slot_mac[k] = '0;
			end
			next_victim = 0;
			mismatches  = 0;
		endfunction

		function void note_request(logic req_mode, logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
			int     k;
			int     slot;
			bit     found;
			reply_t r;
			found = 1'b0;
			slot  = 0;
			// Only the lowest-indexed matching slot counts.
			for (k = 0; k < DEPTH; k++) begin
				if (!found && slot_ip[k] == ip) begin
					found = 1'b1;
					slot  = k;
				end
			end
			r.hit = found;
			r.mac = '0;
			if (req_mode == MODE_UPDATE) begin
				if (found) begin
					slot_mac[slot] = mac;
				end else begin
					slot_ip[next_victim]  = ip;
					slot_mac[next_victim] = mac;
					next_victim = (next_victim + 1) % DEPTH;
				end
			end else if (found) begin
				r.mac = slot_mac[slot];
			end
			pending_replies.push_back(r);
		endfunction

		function void note_mismatch(string what);
			if (mismatches < 10)
				$display("mismatch at %0t: %s", $realtime, what);
			mismatches++;
		endfunction

		function void check_response(logic got_hit, logic [MAC_W-1:0] got_mac);
			reply_t want;
			if (pending_replies.size() == 0) begin
				note_mismatch($sformatf("result with no request waiting: hit %0b mac %012h",
					got_hit, got_mac));
				return;
			end
			want = pending_replies.pop_front();
			if (got_hit !== want.hit)
				note_mismatch($sformatf("hit expected %0b, got %0b", want.hit, got_hit));
			if (got_mac !== want.mac)
				note_mismatch($sformatf("found_mac expected %012h, got %012h", want.mac, got_mac));
		endfunction
	endclass

	mac_table_tracker tracker;

	address_resolution_cache_core #(
		.ENTRIES(DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.lookup_ip(lookup_ip),
		.new_mac(new_mac),
		.done(done),
		.hit(hit),
		.found_mac(found_mac)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			tracker.check_response(hit, found_mac);
	end

	initial begin
		#(TIMEOUT_NS);
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [MAC_W-1:0] random_mac();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return r[MAC_W-1:0];
		endcase
	endfunction

	function automatic logic [IP_W-1:0] random_ip();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 7)
			return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
		else if (pick == 7)
			return '0;
		else
			return $urandom();
	endfunction

	// Called right after a falling edge; returns right after the next one
	// following the transfer.
	task automatic send_request(input logic m, input logic [IP_W-1:0] ip,
			input logic [MAC_W-1:0] mac);
		start     = 1'b1;
		mode      = m;
		lookup_ip = ip;
		new_mac   = mac;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		tracker.note_request(m, ip, mac);
		@(negedge clk);
	endtask

	// The request fields carry noise while start is low.
	task automatic idle_for(input int n);
		repeat (n) begin
			start     = 1'b0;
			mode      = 1'($urandom_range(0, 1));
			lookup_ip = $urandom();
			new_mac   = random_mac();
			@(negedge clk);
		end
	endtask

	task automatic wait_all_replies();
		start = 1'b0;
		while (tracker.pending_replies.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int k;
		int sent;
		int burst_len;
		bit paused_midway;
		tracker   = new();
		arst_n    = 1'b0;
		start     = 1'b0;
		mode      = MODE_UPDATE;
		lookup_ip = '0;
		new_mac   = '0;
		addr_pool[0] = '0;
		addr_pool[1] = '1;
		for (k = 2; k < POOL_SIZE; k++)
			addr_pool[k] = $urandom();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// After reset every slot holds address zero, so zero hits slot 0.
		send_request(MODE_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
		send_request(MODE_LOOKUP, 32'hFFFF_FFFF, 48'h0);
		send_request(MODE_UPDATE, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
		send_request(MODE_LOOKUP, 32'h0000_0000, 48'h0);
		// A miss replaces slot 0; zero then resolves to the duplicate in slot 1.
		send_request(MODE_UPDATE, 32'hFFFF_FFFF, 48'h0);
		send_request(MODE_LOOKUP, 32'h0000_0000, 48'h0);
		send_request(MODE_UPDATE, 32'h0000_0000, 48'h0123_4567_89AB);
		send_request(MODE_LOOKUP, 32'h0000_0000, 48'h0);
		// A lookup miss must leave the table alone.
		send_request(MODE_LOOKUP, 32'h8000_0001, 48'hFFFF_FFFF_FFFF);
		// Sixteen inserts walk the victim pointer past the end of the table.
		for (k = 0; k < DEPTH; k++)
			send_request(MODE_UPDATE, 32'h0A00_0001 + k, {16'hA5A5, 32'h0 + k});
		wait_all_replies();

		sent = 0;
		paused_midway = 1'b0;
		while (sent < RANDOM_REQS) begin
			burst_len = $urandom_range(1, 16);
			repeat (burst_len) begin
				send_request(1'($urandom_range(0, 1)), random_ip(), random_mac());
				sent++;
			end
			if ((!paused_midway && sent >= RANDOM_REQS / 2) || $urandom_range(0, 11) == 0) begin
				paused_midway = 1'b1;
				wait_all_replies();
			end
			if ($urandom_range(0, 3) != 0)
				idle_for($urandom_range(1, MAX_GAP));
		end

		wait_all_replies();
		repeat (DEPTH + 4) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending_replies.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
